@@ src/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helper functions shared by the Playfair digram
// encryptor and its grid stores.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned GridSide  = 5;
  localparam int unsigned GridCells = 25;
  localparam int unsigned Letters   = 26;

  localparam logic [4:0] LetterI    = 5'd8;
  localparam logic [4:0] LetterJ    = 5'd9;
  localparam logic [4:0] LetterX    = 5'd23;
  localparam logic [4:0] LastLetter = 5'd25;
  localparam logic [4:0] CellCount  = 5'd25;
  localparam logic [6:0] AsciiA     = 7'h41;

  typedef enum logic [2:0] {
    CMD_BEGIN_KEY  = 3'd0,
    CMD_KEY_BYTE   = 3'd1,
    CMD_FINISH_KEY = 3'd2,
    CMD_TEXT_BYTE  = 3'd3,
    CMD_END_MSG    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

  // one write port of a grid store
  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [4:0] data;
  } mem_wr_t;

  // two read addresses of a grid store
  typedef struct packed {
    logic [4:0] addr_a;
    logic [4:0] addr_b;
  } rd_req_t;

  typedef struct packed {
    logic       vld;
    logic [4:0] idx;
  } flt_t;

  // letter index of an ASCII byte, J folded onto I
  function automatic flt_t filter_byte(input logic [7:0] b);
    flt_t       f;
    logic [7:0] v;
    v = b;
    if (b >= 8'h61 && b <= 8'h7a) begin
      v = b - 8'd32;
    end
    f.vld = (v >= 8'h41) && (v <= 8'h5a);
    f.idx = 5'(v - 8'h41);
    if (f.idx == LetterJ) begin
      f.idx = LetterI;
    end
    return f;
  endfunction

  function automatic logic [2:0] cell_row(input logic [4:0] c);
    logic [2:0] r;
    if (c >= 5'd20) begin
      r = 3'd4;
    end else if (c >= 5'd15) begin
      r = 3'd3;
    end else if (c >= 5'd10) begin
      r = 3'd2;
    end else if (c >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] c);
    logic [2:0] r;
    r = cell_row(c);
    return 3'(c - {r, 2'b00} - 5'(r));
  endfunction

  // default grid: alphabet without J in row-major order
  function automatic logic [4:0] dflt_cell_letter(input logic [4:0] c);
    return (c < LetterJ) ? c : 5'(c + 5'd1);
  endfunction

  function automatic logic [4:0] dflt_letter_cell(input logic [4:0] l);
    return (l <= LetterJ) ? ((l == LetterJ) ? LetterI : l) : 5'(l - 5'd1);
  endfunction

endpackage

@@ src/pfe_cell_mem.sv @@
// ----------------------------------------------------------------------------
// pfe_cell_mem
// Grid store: letter held in each of the 25 cells. One write port, two
// registered read ports; unwritten cells read as the default grid.
// ----------------------------------------------------------------------------
module pfe_cell_mem
  import pfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_wr_t    wr_i,
  input  rd_req_t    rd_i,
  output logic [4:0] rd_a_o,
  output logic [4:0] rd_b_o
);

  logic [4:0]           mem_q [GridCells];
  logic [GridCells-1:0] vld_q;
  logic [4:0]           data_a_q, data_b_q, addr_a_q, addr_b_q;
  logic                 hit_a_q, hit_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    data_a_q <= mem_q[rd_i.addr_a];
    data_b_q <= mem_q[rd_i.addr_b];
    addr_a_q <= rd_i.addr_a;
    addr_b_q <= rd_i.addr_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      hit_a_q <= vld_q[rd_i.addr_a];
      hit_b_q <= vld_q[rd_i.addr_b];
    end
  end

  assign rd_a_o = hit_a_q ? data_a_q : dflt_cell_letter(addr_a_q);
  assign rd_b_o = hit_b_q ? data_b_q : dflt_cell_letter(addr_b_q);

endmodule

@@ src/pfe_pos_mem.sv @@
// ----------------------------------------------------------------------------
// pfe_pos_mem
// Grid store: cell of each of the 26 letters. One write port, two
// registered read ports; unwritten entries read as the default grid.
// ----------------------------------------------------------------------------
module pfe_pos_mem
  import pfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_wr_t    wr_i,
  input  rd_req_t    rd_i,
  output logic [4:0] rd_a_o,
  output logic [4:0] rd_b_o
);

  logic [4:0]         mem_q [Letters];
  logic [Letters-1:0] vld_q;
  logic [4:0]         data_a_q, data_b_q, addr_a_q, addr_b_q;
  logic               hit_a_q, hit_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    data_a_q <= mem_q[rd_i.addr_a];
    data_b_q <= mem_q[rd_i.addr_b];
    addr_a_q <= rd_i.addr_a;
    addr_b_q <= rd_i.addr_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      hit_a_q <= vld_q[rd_i.addr_a];
      hit_b_q <= vld_q[rd_i.addr_b];
    end
  end

  assign rd_a_o = hit_a_q ? data_a_q : dflt_letter_cell(addr_a_q);
  assign rd_b_o = hit_b_q ? data_b_q : dflt_letter_cell(addr_b_q);

endmodule

@@ src/playfair_digram_encryptor_unit.sv @@
// ----------------------------------------------------------------------------
// playfair_digram_encryptor_unit
// Playfair encryptor on a 5x5 grid with I and J merged.
// ----------------------------------------------------------------------------
// Usage: requests (cmd_i, char_byte_i) arrive on the in_valid_i/in_ready_o
// channel; ciphertext digrams leave on out_valid_o/out_ready_i.
// Begin key, key byte and text bytes that only open a pair leave in_ready_o high.
// A request that completes a digram reads the letter-to-cell store, then the
// cell-to-letter store; the result is loaded into the output register in the
// emit state, and the next request is taken in that state unless the
// receiver stalls. Finish key walks the 26 letters one per cycle through the
// grid write ports and holds in_ready_o low for the whole walk.
// Reset restores the default grid (alphabet without J) at once through
// per-entry valid bits; no clearing pass is needed.
// A stalled receiver keeps the digram in the output register; a further
// digram then waits in its last stage and input requests are held off.
// ----------------------------------------------------------------------------
module playfair_digram_encryptor_unit
  import pfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cipher_first_o,
  output logic [6:0] cipher_second_o,
  output logic       end_pair_o
);

  state_e      state_q, state_d;
  logic [25:0] letter_used_q;
  logic [4:0]  fill_pos_q, fill_letter_q;
  logic        key_loading_q, pend_vld_q, pair_end_q;
  logic [4:0]  pend_letter_q;
  logic        out_valid_q, end_pair_q;
  logic [6:0]  cipher_first_q, cipher_second_q;

  logic        out_free, dispatch;
  flt_t        flt;
  logic        do_begin, do_key, do_finish, do_open, do_pair, do_clear;
  logic [4:0]  pair_b;
  logic        pair_end;

  logic        place_try, place_en;
  logic [4:0]  place_idx;
  mem_wr_t     cell_wr, pos_wr;
  rd_req_t     cell_rd, pos_rd;
  logic [4:0]  ca, cb, cell_a, cell_b, o1, o2;
  logic [4:0]  o1_q, o2_q;
  logic [2:0]  r1, c1, r2, c2;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_EMIT) && out_free);
  assign dispatch   = in_valid_i && in_ready_o;
  assign flt        = filter_byte(char_byte_i);

  // request decode
  always_comb begin
    do_begin  = 1'b0;
    do_key    = 1'b0;
    do_finish = 1'b0;
    do_open   = 1'b0;
    do_pair   = 1'b0;
    do_clear  = 1'b0;
    pair_b    = LetterX;
    pair_end  = 1'b0;
    if (dispatch) begin
      unique case (cmd_e'(cmd_i))
        CMD_BEGIN_KEY: begin
          do_begin = 1'b1;
        end
        CMD_KEY_BYTE: begin
          do_key = key_loading_q && flt.vld;
        end
        CMD_FINISH_KEY: begin
          do_finish = key_loading_q;
        end
        CMD_TEXT_BYTE: begin
          if (!key_loading_q && flt.vld) begin
            if (!pend_vld_q) begin
              do_open = 1'b1;
            end else if (flt.idx == pend_letter_q) begin
              do_pair = 1'b1;  // doubled letter: pad with X, keep it pending
            end else begin
              do_pair  = 1'b1;
              do_clear = 1'b1;
              pair_b   = flt.idx;
            end
          end
        end
        CMD_END_MSG: begin
          if (!key_loading_q && pend_vld_q) begin
            do_pair  = 1'b1;
            do_clear = 1'b1;
            pair_end = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE, ST_EMIT: begin
        if (dispatch) begin
          if (do_finish) begin
            state_d = ST_FILL;
          end else if (do_pair) begin
            state_d = ST_LOOKUP;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (state_q == ST_EMIT && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (fill_letter_q == LastLetter) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // cell arithmetic on the letter-to-cell read data
  assign ca = cell_a;
  assign cb = cell_b;
  assign r1 = cell_row(ca);
  assign c1 = cell_col(ca);
  assign r2 = cell_row(cb);
  assign c2 = cell_col(cb);

  always_comb begin
    if (r1 == r2) begin
      o1 = (c1 == 3'd4) ? 5'(ca - 5'd4) : 5'(ca + 5'd1);
      o2 = (c2 == 3'd4) ? 5'(cb - 5'd4) : 5'(cb + 5'd1);
    end else if (c1 == c2) begin
      o1 = (r1 == 3'd4) ? 5'(ca - 5'd20) : 5'(ca + 5'd5);
      o2 = (r2 == 3'd4) ? 5'(cb - 5'd20) : 5'(cb + 5'd5);
    end else begin
      o1 = 5'(ca - 5'(c1) + 5'(c2));
      o2 = 5'(cb - 5'(c2) + 5'(c1));
    end
  end

  // store requests
  always_comb begin
    place_idx = (state_q == ST_FILL) ? fill_letter_q : flt.idx;
    place_try = ((state_q == ST_FILL) && (fill_letter_q != LetterJ)) || do_key;
    place_en  = place_try && !letter_used_q[place_idx] && (fill_pos_q < CellCount);

    cell_wr.en   = place_en;
    cell_wr.addr = fill_pos_q;
    cell_wr.data = place_idx;
    pos_wr.en    = place_en;
    pos_wr.addr  = place_idx;
    pos_wr.data  = fill_pos_q;

    pos_rd.addr_a  = pend_letter_q;
    pos_rd.addr_b  = pair_b;
    // a stalled emit keeps re-reading the cells of its own digram
    cell_rd.addr_a = (state_q == ST_EMIT) ? o1_q : o1;
    cell_rd.addr_b = (state_q == ST_EMIT) ? o2_q : o2;
  end

  pfe_pos_mem u_pos_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (pos_wr),
    .rd_i   (pos_rd),
    .rd_a_o (cell_a),
    .rd_b_o (cell_b)
  );

  logic [4:0] let_a, let_b;

  pfe_cell_mem u_cell_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cell_wr),
    .rd_i   (cell_rd),
    .rd_a_o (let_a),
    .rd_b_o (let_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      letter_used_q <= 26'h3FFFDFF;
      fill_pos_q    <= '0;
      fill_letter_q <= '0;
      key_loading_q <= 1'b0;
      pend_vld_q    <= 1'b0;
      pend_letter_q <= '0;
      pair_end_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (do_begin) begin
        letter_used_q <= '0;
        fill_pos_q    <= '0;
        key_loading_q <= 1'b1;
        pend_vld_q    <= 1'b0;
        pend_letter_q <= '0;
      end else if (place_en) begin
        letter_used_q[place_idx] <= 1'b1;
        fill_pos_q               <= 5'(fill_pos_q + 5'd1);
      end

      if (do_finish) begin
        fill_letter_q <= '0;
      end else if (state_q == ST_FILL) begin
        fill_letter_q <= 5'(fill_letter_q + 5'd1);
        if (fill_letter_q == LastLetter) begin
          key_loading_q <= 1'b0;
        end
      end

      if (do_open) begin
        pend_vld_q    <= 1'b1;
        pend_letter_q <= flt.idx;
      end else if (do_clear) begin
        pend_vld_q    <= 1'b0;
        pend_letter_q <= '0;
      end

      if (do_pair) begin
        pair_end_q <= pair_end;
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      o1_q <= o1;
      o2_q <= o2;
    end
    if (state_q == ST_EMIT && out_free) begin
      cipher_first_q  <= 7'(let_a) + AsciiA;
      cipher_second_q <= 7'(let_b) + AsciiA;
      end_pair_q      <= pair_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = cipher_first_q;
  assign cipher_second_o = cipher_second_q;
  assign end_pair_o      = end_pair_q;

  // a completed letter walk always leaves the grid full
  a_fill_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && fill_letter_q == LastLetter) |=> (fill_pos_q == CellCount))
    else $error("grid not full after finish key");

  // the emit stage always lands its digram in the output register
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> out_valid_q)
    else $error("digram lost at emit");

  // no request is taken during the letter walk
  a_fill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !in_ready_o)
    else $error("request taken during letter walk");

  // J is folded before it reaches the pending letter
  a_pend_no_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (pend_letter_q != LetterJ))
    else $error("pending letter is J");

endmodule
